### src/connection_slot_allocator_defines.svh
// Assertion macros for the connection slot allocator.
`ifndef CONNECTION_SLOT_ALLOCATOR_DEFINES_SVH
`define CONNECTION_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection slot allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection slot allocator check failed");

`endif

### src/csa_pkg.sv
// Shared types, codes and defaults for the connection slot allocator.
package csa_pkg;

	// Default pool sizes
	localparam int SLOTS_DEF       = 64;
	localparam int DESCRIPTORS_DEF = 256;

	// Port field widths
	localparam int CMD_W  = 3;
	localparam int DESC_W = 8;
	localparam int SLOT_W = 6;
	localparam int STAT_W = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REGISTER  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_MAPPED   = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNMAPPED = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic clear; // write one entry of the reset sweep
		logic load;  // capture input transfer, issue memory reads
		logic exec;  // apply updates, load output register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last; // sweep counter at final entry
		logic out_hold;   // output register full and stalled
	} dp_status_t;

endpackage

### src/csa_ctrl.sv
// Controller state machine: reset sweep, accept, execute.
module csa_ctrl import csa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status_i,
	output ctrl_cmd_t  cmd_o
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd_o.clear = 1'b0;
		cmd_o.load  = 1'b0;
		cmd_o.exec  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd_o.clear = 1'b1;
				if (status_i.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd_o.load = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait while the previous result is still stalled
				if (!status_i.out_hold) begin
					cmd_o.exec = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### src/csa_datapath.sv
// Datapath: descriptor map, free-link memory, free head and output register.
module csa_datapath import csa_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int DESCRIPTORS = DESCRIPTORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd_i,
	output dp_status_t        status_o,
	input  logic [CMD_W-1:0]  command,
	input  logic [DESC_W-1:0] descriptor,
	input  logic [SLOT_W-1:0] slot_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot_out,
	output logic              found,
	output logic [STAT_W-1:0] status
);

	localparam int SW    = $clog2(SLOTS + 1);  // slot value incl. "none"
	localparam int SAW   = $clog2(SLOTS);      // link address
	localparam int DAW   = $clog2(DESCRIPTORS);
	localparam int CLR_N = (DESCRIPTORS > SLOTS) ? DESCRIPTORS : SLOTS;
	localparam int CW    = $clog2(CLR_N);
	localparam logic [SW-1:0] NONE = SW'(SLOTS);

	// Memories
	logic [SW-1:0] map_mem  [DESCRIPTORS];
	logic [SW-1:0] link_mem [SLOTS];

	logic [CW-1:0]     clr_q;
	logic [SW-1:0]     head_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [DESC_W-1:0] desc_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SW-1:0]     map_rd_q;
	logic [SW-1:0]     link_rd_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              found_q;
	logic [STAT_W-1:0] status_q;

	logic              in_desc_ok;
	logic              head_ok;
	logic              desc_ok;
	logic              slot_ok;
	logic              mapped;
	logic [DAW-1:0]    desc_idx;
	logic [SW-1:0]     slot_val;

	logic              map_we;
	logic [DAW-1:0]    map_wa;
	logic [SW-1:0]     map_wd;
	logic              link_we;
	logic [SAW-1:0]    link_wa;
	logic [SW-1:0]     link_wd;
	logic [SW-1:0]     head_d;
	logic [SW-1:0]     r_slot;
	logic              r_found;
	logic [STAT_W-1:0] r_stat;

	// Operand checks
	assign in_desc_ok = 32'(descriptor) < DESCRIPTORS;
	assign head_ok    = 32'(head_q) < SLOTS;
	assign desc_ok    = 32'(desc_q) < DESCRIPTORS;
	assign slot_ok    = 32'(slot_q) < SLOTS;
	assign mapped     = 32'(map_rd_q) < SLOTS;
	assign desc_idx   = DAW'(32'(desc_q));
	assign slot_val   = SW'(32'(slot_q));

	// Command execution
	always_comb begin
		map_we  = 1'b0;
		map_wa  = desc_idx;
		map_wd  = NONE;
		link_we = 1'b0;
		link_wa = head_q[SAW-1:0];
		link_wd = NONE;
		head_d  = head_q;
		r_slot  = '0;
		r_found = 1'b0;
		r_stat  = ST_OK;
		case (cmd_q)
			CMD_ADD: begin
				if (!desc_ok) begin
					r_stat = ST_UNMAPPED;
				end else if (mapped) begin
					r_stat = ST_MAPPED;
				end else if (!head_ok) begin
					r_stat = ST_EMPTY;
				end else begin
					map_we  = 1'b1;
					map_wd  = head_q;
					link_we = 1'b1;
					head_d  = link_rd_q;
					r_slot  = head_q;
					r_found = 1'b1;
				end
			end
			CMD_RESERVE: begin
				if (!head_ok) begin
					r_stat = ST_EMPTY;
				end else begin
					link_we = 1'b1;
					head_d  = link_rd_q;
					r_slot  = head_q;
					r_found = 1'b1;
				end
			end
			CMD_REGISTER: begin
				if (!desc_ok || !slot_ok) begin
					r_stat = ST_UNMAPPED;
				end else begin
					map_we = 1'b1;
					map_wd = slot_val;
				end
			end
			CMD_UNRESERVE: begin
				if (!slot_ok) begin
					r_stat = ST_UNMAPPED;
				end else begin
					link_we = 1'b1;
					link_wa = slot_val[SAW-1:0];
					link_wd = head_q;
					head_d  = slot_val;
				end
			end
			CMD_DELETE: begin
				if (!desc_ok || !mapped) begin
					r_stat = ST_UNMAPPED;
				end else begin
					link_we = 1'b1;
					link_wa = map_rd_q[SAW-1:0];
					link_wd = head_q;
					head_d  = map_rd_q;
					map_we  = 1'b1;
					r_slot  = map_rd_q;
				end
			end
			CMD_LOOKUP: begin
				if (!desc_ok || !mapped) begin
					r_stat = ST_UNMAPPED;
				end else begin
					r_slot  = map_rd_q;
					r_found = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Descriptor map: sweep write, execute write, registered read
	always_ff @(posedge clk) begin
		if (cmd_i.clear) begin
			if (32'(clr_q) < DESCRIPTORS) begin
				map_mem[DAW'(clr_q)] <= NONE;
			end
		end else if (cmd_i.exec && map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		if (cmd_i.load && in_desc_ok) begin
			map_rd_q <= map_mem[DAW'(32'(descriptor))];
		end
	end

	// Free-link memory: sweep builds the initial chain
	always_ff @(posedge clk) begin
		if (cmd_i.clear) begin
			if (32'(clr_q) < SLOTS) begin
				link_mem[SAW'(clr_q)] <= SW'(32'(clr_q) + 32'd1);
			end
		end else if (cmd_i.exec && link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd_i.load && head_ok) begin
			link_rd_q <= link_mem[head_q[SAW-1:0]];
		end
	end

	// Captured input transfer
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q  <= command;
			desc_q <= descriptor;
			slot_q <= slot_in;
		end
	end

	// Sweep counter and free head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= '0;
		end else begin
			if (cmd_i.clear) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd_i.exec) begin
				head_q <= head_d;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.exec) begin
			slot_out_q <= SLOT_W'(32'(r_slot));
			found_q    <= r_found;
			status_q   <= r_stat;
		end
	end

	assign status_o.clear_last = (clr_q == CW'(CLR_N - 1));
	assign status_o.out_hold   = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign slot_out  = slot_out_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

### src/connection_slot_allocator.sv
// Top level of the connection slot allocator: controller plus datapath.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+-----------------------------
//   input   | in        | in_valid / in_stall  | command, descriptor, slot_in
//   result  | out       | out_valid / out_stall| slot_out, found, status
//
// Each command first captures the transfer and reads the descriptor map and
// free-link memories, then applies updates from the registered read data.
// After reset a sweep writes max(DESCRIPTORS, SLOTS) entries (256 by default)
// before the first transfer is taken.
// A stalled result holds the execute cycle; one further command may be
// captured behind it.
`include "connection_slot_allocator_defines.svh"

module connection_slot_allocator import csa_pkg::*; #(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int DESCRIPTORS = DESCRIPTORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [DESC_W-1:0] descriptor,
	input  logic [SLOT_W-1:0] slot_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot_out,
	output logic              found,
	output logic [STAT_W-1:0] status
);

	ctrl_cmd_t  cmd;
	dp_status_t dp_st;

	csa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status_i (dp_st),
		.cmd_o    (cmd)
	);

	csa_datapath #(
		.SLOTS       (SLOTS),
		.DESCRIPTORS (DESCRIPTORS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_i      (cmd),
		.status_o   (dp_st),
		.command    (command),
		.descriptor (descriptor),
		.slot_in    (slot_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_out   (slot_out),
		.found      (found),
		.status     (status)
	);

	// Checks
	`CSA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`CSA_ASSERT_NEXT(a_exec_gives_result, cmd.exec, out_valid)
	`CSA_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.clear, cmd.load, cmd.exec}))
	`CSA_ASSERT_NOW(a_found_is_ok, out_valid && found, status == ST_OK)

endmodule

### dv/connection_slot_allocator_tb.sv
// Self-checking testbench for the connection slot allocator: directed and random command streams.
module connection_slot_allocator_tb;
	import csa_pkg::*;

	localparam int NSLOT       = SLOTS_DEF;
	localparam int NDESC       = DESCRIPTORS_DEF;
	localparam int PTR_W       = $clog2(SLOTS_DEF + 1);
	localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(SLOTS_DEF);

	// Command codes the block does not define
	localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

	// Idle pacing per side
	localparam int PACE_NONE  = 0;
	localparam int PACE_LIGHT = 1;
	localparam int PACE_FULL  = 2;

	// Command mixes for the random part
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	localparam int TOTAL_ITEMS  = 1950;
	localparam int PHASE_ITEMS  = 100;
	localparam int HOT_N        = 24;
	localparam int HOT_W        = $clog2(HOT_N);
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
		logic [STAT_W-1:0] status;
	} pool_reply_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  command;
	logic [DESC_W-1:0] descriptor;
	logic [SLOT_W-1:0] slot_in;
	logic              out_valid;
	logic              out_stall;
	logic [SLOT_W-1:0] slot_out;
	logic              found;
	logic [STAT_W-1:0] status;

	// Shadow of the pool: map, free-list links and list head
	logic [PTR_W-1:0]  slot_of_desc [NDESC];
	logic [PTR_W-1:0]  link_below [NSLOT];
	logic [PTR_W-1:0]  top_free;

	pool_reply_t       awaited_replies [$];
	pool_reply_t       due;
	logic [SLOT_W-1:0] held_slots [$];
	logic [DESC_W-1:0] hot_desc [HOT_N];

	int tx_pace        = PACE_LIGHT;
	int rx_pace        = PACE_LIGHT;
	int rx_hold_cycles = 0;
	int items_sent     = 0;
	int replies_checked = 0;
	int mismatches     = 0;
	int cycle_count    = 0;
	int status_tally [4] = '{0, 0, 0, 0};

	connection_slot_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.descriptor (descriptor),
		.slot_in    (slot_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot_out   (slot_out),
		.found      (found),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Pool shadow
	// ---------------------------------------------------------------
	function automatic void reset_pool_model();
		int i;
		for (i = 0; i < NDESC; i++)
			slot_of_desc[DESC_W'(i)] = NO_SLOT;
		for (i = 0; i < NSLOT; i++)
			link_below[SLOT_W'(i)] = PTR_W'(i + 1);
		top_free = '0;
	endfunction

	// Take the top free slot; NO_SLOT when the list is empty
	function automatic logic [PTR_W-1:0] pop_free_slot();
		logic [PTR_W-1:0] s;
		s = top_free;
		if (s >= NO_SLOT)
			return NO_SLOT;
		top_free = link_below[s[SLOT_W-1:0]];
		link_below[s[SLOT_W-1:0]] = NO_SLOT;
		return s;
	endfunction

	function automatic void push_free_slot(input logic [PTR_W-1:0] s);
		if (s >= NO_SLOT)
			return;
		link_below[s[SLOT_W-1:0]] = top_free;
		top_free = s;
	endfunction

	// One command against the shadow pool; returns the reply it should produce
	function automatic pool_reply_t apply_pool_command(input logic [CMD_W-1:0] cmd,
			input logic [DESC_W-1:0] desc, input logic [SLOT_W-1:0] slot);
		pool_reply_t      r;
		logic [PTR_W-1:0] s;
		logic             desc_ok;
		logic             slot_ok;
		r = '0;
		r.status = ST_OK;
		desc_ok = (int'(desc) < NDESC);
		slot_ok = (int'(slot) < NSLOT);
		case (cmd)
			CMD_ADD: begin
				if (!desc_ok) begin
					r.status = ST_UNMAPPED;
				end else if (slot_of_desc[desc] < NO_SLOT) begin
					r.status = ST_MAPPED;
				end else begin
					s = pop_free_slot();
					if (s >= NO_SLOT) begin
						r.status = ST_EMPTY;
					end else begin
						slot_of_desc[desc] = s;
						r.slot = SLOT_W'(s);
						r.found = 1'b1;
					end
				end
			end
			CMD_RESERVE: begin
				s = pop_free_slot();
				if (s >= NO_SLOT) begin
					r.status = ST_EMPTY;
				end else begin
					r.slot = SLOT_W'(s);
					r.found = 1'b1;
				end
			end
			CMD_REGISTER: begin
				// overwrites any earlier mapping; the old slot stays where it was
				if (!desc_ok || !slot_ok)
					r.status = ST_UNMAPPED;
				else
					slot_of_desc[desc] = PTR_W'(slot);
			end
			CMD_UNRESERVE: begin
				// pushed without checking whether it is already free, so a slot may sit on the list twice
				if (!slot_ok)
					r.status = ST_UNMAPPED;
				else
					push_free_slot(PTR_W'(slot));
			end
			CMD_DELETE: begin
				if (!desc_ok || slot_of_desc[desc] >= NO_SLOT) begin
					r.status = ST_UNMAPPED;
				end else begin
					s = slot_of_desc[desc];
					push_free_slot(s);
					slot_of_desc[desc] = NO_SLOT;
					r.slot = SLOT_W'(s);
				end
			end
			CMD_LOOKUP: begin
				if (!desc_ok || slot_of_desc[desc] >= NO_SLOT) begin
					r.status = ST_UNMAPPED;
				end else begin
					r.slot = SLOT_W'(slot_of_desc[desc]);
					r.found = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic int pace_gap(input int pace);
		case (pace)
			PACE_NONE:  return 0;
			PACE_LIGHT: return $urandom_range(0, 3);
			default:    return $urandom_range(0, 16);
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_command(input int mix);
		int roll;
		roll = $urandom_range(0, 99);
		// a little noise with the undefined codes
		if (roll < 4)
			return ($urandom_range(0, 1) != 0) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (roll < 40) return CMD_ADD;
				if (roll < 70) return CMD_RESERVE;
				if (roll < 76) return CMD_REGISTER;
				if (roll < 82) return CMD_UNRESERVE;
				if (roll < 90) return CMD_DELETE;
				return CMD_LOOKUP;
			end
			MIX_DRAIN: begin
				if (roll < 10) return CMD_ADD;
				if (roll < 15) return CMD_RESERVE;
				if (roll < 20) return CMD_REGISTER;
				if (roll < 50) return CMD_UNRESERVE;
				if (roll < 80) return CMD_DELETE;
				return CMD_LOOKUP;
			end
			default: begin
				if (roll < 20) return CMD_ADD;
				if (roll < 32) return CMD_RESERVE;
				if (roll < 42) return CMD_REGISTER;
				if (roll < 56) return CMD_UNRESERVE;
				if (roll < 76) return CMD_DELETE;
				return CMD_LOOKUP;
			end
		endcase
	endfunction

	// Mostly a small working set so adds, deletes and lookups hit each other
	function automatic logic [DESC_W-1:0] pick_descriptor();
		if ($urandom_range(0, 99) < 80)
			return hot_desc[HOT_W'($urandom_range(0, HOT_N - 1))];
		return DESC_W'($urandom);
	endfunction

	function automatic void shuffle_hot_descriptors();
		int i;
		for (i = 0; i < HOT_N; i++)
			hot_desc[HOT_W'(i)] = DESC_W'($urandom);
		if ($urandom_range(0, 1) != 0) begin
			hot_desc[0] = '0;
			hot_desc[1] = '1;
		end
	endfunction

	// One command transfer; starts and ends on a falling edge, leaves valid up
	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [DESC_W-1:0] desc,
			input logic [SLOT_W-1:0] slot);
		int          gap;
		pool_reply_t reply;
		gap = pace_gap(tx_pace);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		command    = cmd;
		descriptor = desc;
		slot_in    = slot;
		do @(posedge clk); while (in_stall !== 1'b0);
		reply = apply_pool_command(cmd, desc, slot);
		if (cmd == CMD_RESERVE && reply.found)
			held_slots.push_back(reply.slot);
		awaited_replies.push_back(reply);
		status_tally[reply.status]++;
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait for every awaited reply
	task automatic wait_replies_drained();
		in_valid = 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_empty_map();
		issue_command(CMD_LOOKUP, 8'd0, 6'd0);
		issue_command(CMD_LOOKUP, 8'd255, 6'd63);
		issue_command(CMD_DELETE, 8'd0, 6'd0);
	endtask

	task automatic test_add_lookup();
		issue_command(CMD_ADD, 8'd0, 6'd63);
		issue_command(CMD_ADD, 8'd255, 6'd0);
		issue_command(CMD_ADD, 8'd0, 6'd0);
		issue_command(CMD_LOOKUP, 8'd0, 6'd0);
		issue_command(CMD_LOOKUP, 8'd255, 6'd0);
	endtask

	task automatic test_register_overwrite();
		issue_command(CMD_REGISTER, 8'd7, 6'd63);
		issue_command(CMD_REGISTER, 8'd7, 6'd0);
		issue_command(CMD_LOOKUP, 8'd7, 6'd0);
		issue_command(CMD_REGISTER, 8'd255, 6'd63);
	endtask

	// Includes pushing a slot that is already free
	task automatic test_reserve_unreserve();
		issue_command(CMD_RESERVE, 8'd0, 6'd0);
		issue_command(CMD_UNRESERVE, 8'd0, 6'd2);
		issue_command(CMD_UNRESERVE, 8'd255, 6'd63);
		issue_command(CMD_UNRESERVE, 8'd0, 6'd5);
		issue_command(CMD_RESERVE, 8'd0, 6'd0);
		issue_command(CMD_RESERVE, 8'd0, 6'd0);
	endtask

	task automatic test_delete();
		issue_command(CMD_DELETE, 8'd0, 6'd0);
		issue_command(CMD_DELETE, 8'd0, 6'd0);
		issue_command(CMD_LOOKUP, 8'd0, 6'd0);
	endtask

	task automatic test_undefined_commands();
		issue_command(CMD_UNDEF_LO, 8'd255, 6'd63);
		issue_command(CMD_UNDEF_HI, 8'd0, 6'd0);
	endtask

	// Pop until the list runs dry, hit it empty, then hand the slots back
	task automatic test_pool_exhaustion();
		logic [DESC_W-1:0] d;
		while (top_free != NO_SLOT)
			issue_command(CMD_RESERVE, DESC_W'($urandom), SLOT_W'($urandom));
		issue_command(CMD_RESERVE, DESC_W'($urandom), SLOT_W'($urandom));
		do d = DESC_W'($urandom); while (slot_of_desc[d] != NO_SLOT);
		issue_command(CMD_ADD, d, SLOT_W'($urandom));
		issue_command(CMD_LOOKUP, d, SLOT_W'($urandom));
		while (held_slots.size() > 0)
			issue_command(CMD_UNRESERVE, DESC_W'($urandom), held_slots.pop_front());
	endtask

	// Receiver holds off for a long stretch while commands keep coming
	task automatic test_backpressure();
		wait_replies_drained();
		tx_pace = PACE_NONE;
		rx_hold_cycles = LONG_HOLD;
		repeat (24)
			issue_command(pick_command(MIX_EVEN), pick_descriptor(), SLOT_W'($urandom));
		tx_pace = PACE_FULL;
	endtask

	task automatic test_random_mix(input int target);
		int                mix;
		int                idx;
		logic [CMD_W-1:0]  cmd;
		logic [SLOT_W-1:0] slot;
		while (items_sent < target) begin
			mix = $urandom_range(MIX_FILL, MIX_EVEN);
			tx_pace = $urandom_range(PACE_NONE, PACE_FULL);
			rx_pace = $urandom_range(PACE_NONE, PACE_FULL);
			shuffle_hot_descriptors();
			repeat (PHASE_ITEMS) begin
				cmd = pick_command(mix);
				slot = SLOT_W'($urandom);
				// mostly give back slots that were actually reserved
				if (cmd == CMD_UNRESERVE && held_slots.size() > 0 &&
						$urandom_range(0, 99) < 85) begin
					idx = $urandom_range(0, held_slots.size() - 1);
					slot = held_slots[idx];
					held_slots.delete(idx);
				end
				issue_command(cmd, pick_descriptor(), slot);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: stall pacing and checking
	// ---------------------------------------------------------------
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_stall = 1'b1;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end
			n = pace_gap(rx_pace);
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Compare each result transfer with the oldest awaited reply
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_replies.size() == 0) begin
				$error("unexpected result transfer: slot_out %0d found %0b status %0d",
					slot_out, found, status);
				mismatches++;
			end else begin
				due = awaited_replies.pop_front();
				replies_checked++;
				if (slot_out !== due.slot) begin
					$error("slot_out: expected %0d, actual %0d", due.slot, slot_out);
					mismatches++;
				end
				if (found !== due.found) begin
					$error("found: expected %0b, actual %0b", due.found, found);
					mismatches++;
				end
				if (status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, status);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		command    = '0;
		descriptor = '0;
		slot_in    = '0;
		reset_pool_model();
		shuffle_hot_descriptors();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_map();
		test_add_lookup();
		test_register_overwrite();
		test_reserve_unreserve();
		test_delete();
		test_undefined_commands();
		test_pool_exhaustion();
		test_backpressure();
		test_random_mix(TOTAL_ITEMS);

		wait_replies_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d commands sent, %0d replies checked, %0d mismatches",
			items_sent, replies_checked, mismatches);
		$display("replies by status: ok %0d, pool empty %0d, already mapped %0d, not mapped %0d",
			status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_MAPPED],
			status_tally[ST_UNMAPPED]);
		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
